/* src/fpx_pkg.sv */
// ----------------------------------------------------------------------------
// fpx_pkg
// Shared constants for the frame parser: field widths, register indexes,
// status codes and payload store sizing.
// ----------------------------------------------------------------------------
package fpx_pkg;

	localparam int MAX_PAYLOAD = 32;
	localparam int PAYLOAD_AW  = $clog2(MAX_PAYLOAD);

	localparam int BYTE_W   = 8;
	localparam int LEN_W    = 6;
	localparam int IDX_W    = 5;
	localparam int STATUS_W = 2;
	localparam int REG_IDX_W = 1;

	typedef logic [BYTE_W-1:0]   byte_t;
	typedef logic [LEN_W-1:0]    len_t;
	typedef logic [IDX_W-1:0]    idx_t;
	typedef logic [STATUS_W-1:0] status_t;
	typedef logic [REG_IDX_W-1:0] reg_idx_t;

	// register indexes
	localparam reg_idx_t REG_START_BYTE   = 1'd0;
	localparam reg_idx_t REG_LENGTH_LIMIT = 1'd1;

	localparam byte_t START_BYTE_RST   = 8'hAA;
	localparam len_t  LENGTH_LIMIT_RST = 6'd32;

	// result status codes
	localparam status_t ST_GOOD     = 2'd0;
	localparam status_t ST_LEN_OVER = 2'd1;
	localparam status_t ST_BAD_SUM  = 2'd2;

endpackage

/* src/fpx_ram.sv */
// ----------------------------------------------------------------------------
// fpx_ram
// Generic single-clock RAM, one write port and one read port, registered
// read data that holds its value while no read is issued.
// ----------------------------------------------------------------------------
module fpx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/frame_parser_xor_checksum_unit.sv */
// ----------------------------------------------------------------------------
// frame_parser_xor_checksum_unit
// Start/type/length/payload/checksum frame parser with XOR checksum. Payload
// bytes go to a synchronous RAM and are read back one per cycle, unless the
// output stalls, as a burst of result words once the checksum byte matches.
// ----------------------------------------------------------------------------
// an error or empty-frame word appears in the cycle after its byte
// throughput: one input byte per cycle outside result bursts and output stalls
// a good frame of n payload bytes gives n words, each read through the RAM
// output register, one a cycle unless the output stalls; input waits meanwhile
// reset: parser hunts for the start byte, registers return to 0xAA and 32;
// the payload RAM is not cleared, every entry is written before it is read
module frame_parser_xor_checksum_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  fpx_pkg::reg_idx_t        wr_index,
	input  fpx_pkg::byte_t           wr_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  fpx_pkg::byte_t           rx_byte,
	output logic                     out_valid,
	input  logic                     out_ready,
	output fpx_pkg::status_t         status,
	output fpx_pkg::byte_t           frame_type,
	output fpx_pkg::len_t            frame_len,
	output fpx_pkg::idx_t            elem_index,
	output fpx_pkg::byte_t           elem_byte,
	output logic                     elem_valid,
	output logic                     last
);

	import fpx_pkg::*;

	localparam logic [2:0] PH_HUNT    = 3'd0;
	localparam logic [2:0] PH_TYPE    = 3'd1;
	localparam logic [2:0] PH_LEN     = 3'd2;
	localparam logic [2:0] PH_PAYLOAD = 3'd3;
	localparam logic [2:0] PH_CHECK   = 3'd4;
	localparam logic [2:0] PH_BURST   = 3'd5;

	logic [2:0] phase_q;
	byte_t      start_byte_q;
	len_t       length_limit_q;
	byte_t      held_type_q;
	len_t       held_len_q;
	len_t       byte_count_q;
	byte_t      running_xor_q;
	len_t       rd_idx_q;
	len_t       idx_s1;
	logic       pend_s1;

	logic       out_valid_q;
	status_t    status_q;
	byte_t      frame_type_q;
	len_t       frame_len_q;
	idx_t       elem_index_q;
	byte_t      elem_byte_q;
	logic       elem_valid_q;
	logic       last_q;

	logic       out_free;
	logic       in_acc;
	logic       rd_load;
	logic       rd_issue;
	len_t       eff_limit;
	len_t       count_next;
	len_t       idx_next;
	byte_t      ram_rdata;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (phase_q != PH_BURST) && out_free;
	assign in_acc    = in_valid && in_ready;
	assign eff_limit = (length_limit_q > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
		: length_limit_q;
	assign count_next = byte_count_q + 1'b1;
	assign idx_next   = idx_s1 + 1'b1;

	// read data waits in the RAM output register until the output word frees up
	assign rd_load  = (phase_q == PH_BURST) && pend_s1 && out_free;
	assign rd_issue = (phase_q == PH_BURST) && (rd_idx_q < held_len_q)
		&& (!pend_s1 || rd_load);

	fpx_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(MAX_PAYLOAD)
	) u_payload_ram (
		.clk   (clk),
		.we    (in_acc && (phase_q == PH_PAYLOAD)),
		.waddr (byte_count_q[PAYLOAD_AW-1:0]),
		.wdata (rx_byte),
		.re    (rd_issue),
		.raddr (rd_idx_q[PAYLOAD_AW-1:0]),
		.rdata (ram_rdata)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_byte_q   <= START_BYTE_RST;
			length_limit_q <= LENGTH_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_START_BYTE:   start_byte_q   <= wr_data;
				REG_LENGTH_LIMIT: length_limit_q <= wr_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// parser control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HUNT;
			held_type_q   <= '0;
			held_len_q    <= '0;
			byte_count_q  <= '0;
			running_xor_q <= '0;
			rd_idx_q      <= '0;
			pend_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				case (phase_q)
					PH_TYPE: begin
						held_type_q   <= rx_byte;
						running_xor_q <= rx_byte;
						phase_q       <= PH_LEN;
					end
					PH_LEN: begin
						running_xor_q <= running_xor_q ^ rx_byte;
						byte_count_q  <= '0;
						if (rx_byte > {2'b00, eff_limit}) begin
							held_len_q  <= '0;
							phase_q     <= PH_HUNT;
							out_valid_q <= 1'b1;
						end else begin
							held_len_q <= rx_byte[LEN_W-1:0];
							phase_q    <= (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
						end
					end
					PH_PAYLOAD: begin
						running_xor_q <= running_xor_q ^ rx_byte;
						byte_count_q  <= count_next;
						if (count_next >= held_len_q) begin
							phase_q <= PH_CHECK;
						end
					end
					PH_CHECK: begin
						if (rx_byte != running_xor_q || held_len_q == '0) begin
							phase_q     <= PH_HUNT;
							out_valid_q <= 1'b1;
						end else begin
							phase_q  <= PH_BURST;
							rd_idx_q <= '0;
							pend_s1  <= 1'b0;
						end
					end
					default: begin
						phase_q <= (rx_byte == start_byte_q) ? PH_TYPE : PH_HUNT;
					end
				endcase
			end
			if (phase_q == PH_BURST) begin
				if (rd_issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
					pend_s1  <= 1'b1;
				end else if (rd_load) begin
					pend_s1 <= 1'b0;
				end
				if (rd_load) begin
					out_valid_q <= 1'b1;
					if (idx_next == held_len_q) begin
						phase_q <= PH_HUNT;
					end
				end
			end
		end
	end

	// read index tracks the word that sits in the RAM output register
	always_ff @(posedge clk) begin
		if (rd_issue) begin
			idx_s1 <= rd_idx_q;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (in_acc && phase_q == PH_LEN) begin
			status_q     <= ST_LEN_OVER;
			frame_type_q <= held_type_q;
			frame_len_q  <= '0;
			elem_index_q <= '0;
			elem_byte_q  <= '0;
			elem_valid_q <= 1'b0;
			last_q       <= 1'b1;
		end else if (in_acc && phase_q == PH_CHECK) begin
			status_q     <= (rx_byte != running_xor_q) ? ST_BAD_SUM : ST_GOOD;
			frame_type_q <= held_type_q;
			frame_len_q  <= held_len_q;
			elem_index_q <= '0;
			elem_byte_q  <= '0;
			elem_valid_q <= 1'b0;
			last_q       <= 1'b1;
		end else if (rd_load) begin
			status_q     <= ST_GOOD;
			frame_type_q <= held_type_q;
			frame_len_q  <= held_len_q;
			elem_index_q <= idx_s1[IDX_W-1:0];
			elem_byte_q  <= ram_rdata;
			elem_valid_q <= 1'b1;
			last_q       <= (idx_next == held_len_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign frame_type = frame_type_q;
	assign frame_len  = frame_len_q;
	assign elem_index = elem_index_q;
	assign elem_byte  = elem_byte_q;
	assign elem_valid = elem_valid_q;
	assign last       = last_q;

endmodule
